// File: rtl/gppl_pkg.sv
// ----------------------------------------------------------------------------
// gppl_pkg - grid peak pixel locator shared definitions
// Register codes, field widths, reset values and mapping constants.
// ----------------------------------------------------------------------------
package gppl_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MARGIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_STEP       = 3'd4;

	localparam int DIM_W    = 10;
	localparam int MARGIN_W = 9;
	localparam int THR_W    = 8;
	localparam int STEP_W   = 6;

	localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 10'd640;
	localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 10'd480;
	localparam logic [MARGIN_W-1:0] RST_EDGE_MARGIN  = 9'd40;
	localparam logic [THR_W-1:0]    RST_THRESHOLD    = 8'd20;
	localparam logic [STEP_W-1:0]   RST_GRID_STEP    = 6'd5;

	localparam int SCREEN_X_W = 16;
	localparam int SCREEN_Y_W = 15;

	// screen_x = 4096*(3x+2)/443, screen_y = -(256*(27y-90)/260) = -(64*(27y-90)/65)
	localparam int DIV_X    = 443;
	localparam int DIV_Y    = 65;
	localparam int Y_OFFSET = 90;
	localparam int Y_SCALE  = 27;

	localparam int SX_MAX = 32767;
	localparam int SY_MAX = 16383;
	localparam int SY_MIN_MAG = 16384;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// File: rtl/gppl_front.sv
// ----------------------------------------------------------------------------
// gppl_front - pixel intake and peak search
// Holds the registers, tracks raster position and grid phase, keeps the
// running peak and queues one record per completed frame.
// ----------------------------------------------------------------------------
module gppl_front #(
	parameter int COORD_BITS = 10,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gppl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gppl_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic [PIXEL_BITS-1:0]               pixel,
	input  logic                                frame_start,
	input  gppl_pkg::qstat_t                    qstat,
	output logic                                enq,
	output logic [2*COORD_BITS+PIXEL_BITS:0]    enq_data
);
	import gppl_pkg::*;

	localparam int XW = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;
	localparam int TW = (PIXEL_BITS > THR_W) ? PIXEL_BITS : THR_W;
	localparam int BW = $clog2(COORD_BITS);

	logic [DIM_W-1:0]      fw_q, fh_q;
	logic [MARGIN_W-1:0]   mg_q;
	logic [THR_W-1:0]      thr_q;
	logic [STEP_W-1:0]     step_q;

	logic [COORD_BITS-1:0] col_q, row_q, bx_q, by_q;
	logic [STEP_W-1:0]     xm_q, ym_q;
	logic [PIXEL_BITS-1:0] best_q;
	logic                  have_q;

	logic                  busy_q;
	logic [BW-1:0]         cnt_q;
	logic [STEP_W-1:0]     rx_q, ry_q;

	logic [STEP_W-1:0]     step_e, xm_e, ym_e, xm_n, ym_n, rx_n, ry_n;
	logic [STEP_W:0]       xm_inc, ym_inc, rx_sh, ry_sh;
	logic [DIM_W-1:0]      w_e, h_e;
	logic [COORD_BITS-1:0] x_e, y_e, bx_n, by_n;
	logic [PIXEL_BITS-1:0] best_e, best_n;
	logic                  have_e, have_n;
	logic [XW-1:0]         xx, yy, mm, ww, hh;
	logic                  in_x, in_y, hit, line_end, frame_end, accept, cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign full      = qstat.full || busy_q || (cfg_wr && cfg_index == CFG_GRID_STEP);
	assign accept    = push && !full;

	always_comb begin
		step_e = (step_q == '0) ? STEP_W'(1) : step_q;
		w_e    = (fw_q == '0) ? DIM_W'(1) : fw_q;
		h_e    = (fh_q == '0) ? DIM_W'(1) : fh_q;
		x_e    = frame_start ? '0 : col_q;
		y_e    = frame_start ? '0 : row_q;
		xm_e   = frame_start ? '0 : xm_q;
		ym_e   = frame_start ? '0 : ym_q;
		have_e = frame_start ? 1'b0 : have_q;
		best_e = frame_start ? '0 : best_q;

		xx = XW'(x_e);
		yy = XW'(y_e);
		mm = XW'(mg_q);
		ww = XW'(w_e);
		hh = XW'(h_e);

		in_x = (xm_e == '0) && (xx >= mm) && (xx + mm <= ww);
		in_y = (ym_e == '0) && (yy >= mm) && (yy + mm <= hh);
		hit  = in_x && in_y && (TW'(pixel) > TW'(thr_q)) && (!have_e || pixel > best_e);

		have_n = have_e || hit;
		best_n = hit ? pixel : best_e;
		bx_n   = hit ? x_e : (frame_start ? '0 : bx_q);
		by_n   = hit ? y_e : (frame_start ? '0 : by_q);

		line_end  = (xx + XW'(1) >= ww) || (x_e == {COORD_BITS{1'b1}});
		frame_end = line_end && ((yy + XW'(1) >= hh) || (y_e == {COORD_BITS{1'b1}}));

		xm_inc = (STEP_W+1)'(xm_e) + (STEP_W+1)'(1);
		ym_inc = (STEP_W+1)'(ym_e) + (STEP_W+1)'(1);
		xm_n   = (xm_inc >= (STEP_W+1)'(step_e)) ? '0 : xm_inc[STEP_W-1:0];
		ym_n   = (ym_inc >= (STEP_W+1)'(step_e)) ? '0 : ym_inc[STEP_W-1:0];

		// restoring remainder, one bit of each counter per cycle
		rx_sh = {rx_q, col_q[cnt_q]};
		ry_sh = {ry_q, row_q[cnt_q]};
		rx_n  = (rx_sh >= (STEP_W+1)'(step_e)) ?
			STEP_W'(rx_sh - (STEP_W+1)'(step_e)) : rx_sh[STEP_W-1:0];
		ry_n  = (ry_sh >= (STEP_W+1)'(step_e)) ?
			STEP_W'(ry_sh - (STEP_W+1)'(step_e)) : ry_sh[STEP_W-1:0];

		enq      = accept && frame_end;
		enq_data = {have_n, bx_n, by_n, best_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q   <= RST_FRAME_WIDTH;
			fh_q   <= RST_FRAME_HEIGHT;
			mg_q   <= RST_EDGE_MARGIN;
			thr_q  <= RST_THRESHOLD;
			step_q <= RST_GRID_STEP;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:     fw_q   <= cfg_data[DIM_W-1:0];
				CFG_FRAME_HEIGHT:    fh_q   <= cfg_data[DIM_W-1:0];
				CFG_EDGE_MARGIN:     mg_q   <= cfg_data[MARGIN_W-1:0];
				CFG_LEVEL_THRESHOLD: thr_q  <= cfg_data[THR_W-1:0];
				CFG_GRID_STEP:       step_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			xm_q   <= '0;
			ym_q   <= '0;
			best_q <= '0;
			bx_q   <= '0;
			by_q   <= '0;
			have_q <= 1'b0;
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rx_q   <= '0;
			ry_q   <= '0;
		end else if (cfg_wr && cfg_index == CFG_GRID_STEP) begin
			busy_q <= 1'b1;
			cnt_q  <= BW'(COORD_BITS-1);
			rx_q   <= '0;
			ry_q   <= '0;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				xm_q   <= rx_n;
				ym_q   <= ry_n;
			end else begin
				cnt_q <= cnt_q - BW'(1);
				rx_q  <= rx_n;
				ry_q  <= ry_n;
			end
		end else if (accept) begin
			if (frame_end) begin
				col_q  <= '0;
				row_q  <= '0;
				xm_q   <= '0;
				ym_q   <= '0;
				best_q <= '0;
				bx_q   <= '0;
				by_q   <= '0;
				have_q <= 1'b0;
			end else begin
				best_q <= best_n;
				bx_q   <= bx_n;
				by_q   <= by_n;
				have_q <= have_n;
				if (line_end) begin
					col_q <= '0;
					xm_q  <= '0;
					row_q <= y_e + COORD_BITS'(1);
					ym_q  <= ym_n;
				end else begin
					col_q <= x_e + COORD_BITS'(1);
					xm_q  <= xm_n;
					row_q <= y_e;
					ym_q  <= ym_e;
				end
			end
		end
	end

endmodule

// File: rtl/gppl_queue.sv
// ----------------------------------------------------------------------------
// gppl_queue - frame record queue
// Short register queue between the peak search and the coordinate mapper.
// ----------------------------------------------------------------------------
module gppl_queue #(
	parameter int WIDTH = 29,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output gppl_pkg::qstat_t qstat
);
	import gppl_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign qstat.full  = (cnt_q == CW'(DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_wr       = wr_en && !qstat.full;
	assign do_rd       = rd_en && !qstat.empty;
	assign rd_data     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(do_wr) - CW'(do_rd);
		end
	end

endmodule

// File: rtl/gppl_back.sv
// ----------------------------------------------------------------------------
// gppl_back - screen coordinate mapper
// Four-stage pipeline: numerators, reciprocal products, back products, and
// quotient correction with clamping into the result register.
// ----------------------------------------------------------------------------
module gppl_back #(
	parameter int COORD_BITS = 10,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  gppl_pkg::qstat_t                        qstat,
	input  logic [2*COORD_BITS+PIXEL_BITS:0]        rec,
	output logic                                    deq,
	output logic                                    empty,
	input  logic                                    pop,
	output logic                                    found,
	output logic [COORD_BITS-1:0]                   peak_x,
	output logic [COORD_BITS-1:0]                   peak_y,
	output logic [PIXEL_BITS-1:0]                   peak_level,
	output logic signed [gppl_pkg::SCREEN_X_W-1:0]  screen_x,
	output logic signed [gppl_pkg::SCREEN_Y_W-1:0]  screen_y
);
	import gppl_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int P   = PIXEL_BITS;
	localparam int NXW = C + 14;
	localparam int RXW = NXW - 8;
	localparam int NYW = C + 11;
	localparam int RYW = NYW - 6;
	localparam int TYW = C + 5;
	localparam int XEW = (RXW + 1 > SCREEN_X_W) ? RXW + 1 : SCREEN_X_W;
	localparam int YEW = (RYW + 1 > SCREEN_Y_W) ? RYW + 1 : SCREEN_Y_W;
	localparam longint RX_L = (longint'(1) << NXW) / DIV_X;
	localparam longint RY_L = (longint'(1) << NYW) / DIV_Y;
	localparam logic [RXW-1:0] RX = RXW'(RX_L);
	localparam logic [RYW-1:0] RY = RYW'(RY_L);

	logic                v_s1, v_s2, v_s3, v_q;
	logic                adv1, adv2, adv3, adv_o;

	logic                found_s1, found_s2, found_s3, found_q;
	logic [C-1:0]        px_s1, px_s2, px_s3, py_s1, py_s2, py_s3, peak_x_q, peak_y_q;
	logic [P-1:0]        lv_s1, lv_s2, lv_s3, peak_level_q;
	logic [NXW-1:0]      nx_s1, nx_s2, nx_s3, qdx_s3;
	logic [NYW-1:0]      ny_s1, ny_s2, ny_s3, qdy_s3;
	logic                yn_s1, yn_s2, yn_s3;
	logic [NXW+RXW-1:0]  prx_s2;
	logic [NYW+RYW-1:0]  pry_s2;
	logic [RXW-1:0]      qx_s3;
	logic [RYW-1:0]      qy_s3;
	logic signed [SCREEN_X_W-1:0] screen_x_q;
	logic signed [SCREEN_Y_W-1:0] screen_y_q;

	logic                rf;
	logic [C-1:0]        rpx, rpy;
	logic [P-1:0]        rlv;
	logic [TYW-1:0]      t27, mag;
	logic                yneg;
	logic [NXW-1:0]      nx_c, remx;
	logic [NYW-1:0]      ny_c, remy;
	logic [RXW-1:0]      qx_c;
	logic [RYW-1:0]      qy_c;
	logic [XEW-1:0]      qxf;
	logic [YEW-1:0]      qyf;
	logic [SCREEN_X_W-1:0] sx_c;
	logic [SCREEN_Y_W-1:0] sy_c;

	assign adv_o = !v_q || pop;
	assign adv3  = !v_s3 || adv_o;
	assign adv2  = !v_s2 || adv3;
	assign adv1  = !v_s1 || adv2;
	assign deq   = adv1 && !qstat.empty;
	assign empty = !v_q;

	assign found      = found_q;
	assign peak_x     = peak_x_q;
	assign peak_y     = peak_y_q;
	assign peak_level = peak_level_q;
	assign screen_x   = screen_x_q;
	assign screen_y   = screen_y_q;

	always_comb begin
		{rf, rpx, rpy, rlv} = rec;
		nx_c = (NXW'(rpx) * NXW'(3) + NXW'(2)) << 12;
		t27  = TYW'(rpy) * TYW'(Y_SCALE);
		yneg = t27 < TYW'(Y_OFFSET);
		mag  = yneg ? TYW'(Y_OFFSET) - t27 : t27 - TYW'(Y_OFFSET);
		ny_c = NYW'(mag) << 6;

		qx_c = prx_s2[NXW+RXW-1:NXW];
		qy_c = pry_s2[NYW+RYW-1:NYW];

		remx = nx_s3 - qdx_s3;
		remy = ny_s3 - qdy_s3;
		qxf  = XEW'(qx_s3) + XEW'(remx >= NXW'(DIV_X));
		qyf  = YEW'(qy_s3) + YEW'(remy >= NYW'(DIV_Y));
		sx_c = (qxf > XEW'(SX_MAX)) ? SCREEN_X_W'(SX_MAX) : qxf[SCREEN_X_W-1:0];
		if (yn_s3) begin
			sy_c = (qyf > YEW'(SY_MAX)) ? SCREEN_Y_W'(SY_MAX) : qyf[SCREEN_Y_W-1:0];
		end else begin
			sy_c = (qyf > YEW'(SY_MIN_MAG)) ? SCREEN_Y_W'(YEW'(0) - YEW'(SY_MIN_MAG)) :
				SCREEN_Y_W'(YEW'(0) - qyf);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (adv1) v_s1 <= !qstat.empty;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv_o) v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			found_s1 <= rf;
			px_s1    <= rpx;
			py_s1    <= rpy;
			lv_s1    <= rlv;
			nx_s1    <= nx_c;
			ny_s1    <= ny_c;
			yn_s1    <= yneg;
		end
		if (adv2) begin
			found_s2 <= found_s1;
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			lv_s2    <= lv_s1;
			nx_s2    <= nx_s1;
			ny_s2    <= ny_s1;
			yn_s2    <= yn_s1;
			prx_s2   <= (NXW+RXW)'(nx_s1) * (NXW+RXW)'(RX);
			pry_s2   <= (NYW+RYW)'(ny_s1) * (NYW+RYW)'(RY);
		end
		if (adv3) begin
			found_s3 <= found_s2;
			px_s3    <= px_s2;
			py_s3    <= py_s2;
			lv_s3    <= lv_s2;
			nx_s3    <= nx_s2;
			ny_s3    <= ny_s2;
			yn_s3    <= yn_s2;
			qx_s3    <= qx_c;
			qy_s3    <= qy_c;
			qdx_s3   <= NXW'(qx_c) * NXW'(DIV_X);
			qdy_s3   <= NYW'(qy_c) * NYW'(DIV_Y);
		end
		if (adv_o) begin
			found_q      <= found_s3;
			peak_x_q     <= found_s3 ? px_s3 : '0;
			peak_y_q     <= found_s3 ? py_s3 : '0;
			peak_level_q <= found_s3 ? lv_s3 : '0;
			screen_x_q   <= found_s3 ? sx_c : '0;
			screen_y_q   <= found_s3 ? sy_c : '0;
		end
	end

`ifndef NO_ASSERTIONS
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && !found_q) |-> (peak_x_q == '0 && peak_y_q == '0 &&
			screen_x_q == '0 && screen_y_q == '0))
		else $error("empty frame result carries nonzero fields");

	a_sx_sign: assert property (@(posedge clk) disable iff (!arst_n)
		v_q |-> !screen_x_q[SCREEN_X_W-1])
		else $error("screen_x went negative");

	a_sy_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && found_q && peak_y_q > C'(3)) |-> screen_y_q[SCREEN_Y_W-1])
		else $error("screen_y sign wrong for lower rows");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !adv3) |=> (v_s3 && $stable(qx_s3) && $stable(qy_s3)))
		else $error("stalled mapper stage lost its request");
`endif

endmodule

// File: rtl/grid_peak_pixel_locator.sv
// ----------------------------------------------------------------------------
// grid_peak_pixel_locator - grid-sampled frame peak finder
// Finds the largest sampled pixel above threshold in each raster frame and
// reports its position and its mapped screen coordinates.
// ----------------------------------------------------------------------------
// channel   signals                                   accepted when
// pixels    push full pixel frame_start               push && !full
// results   empty pop found peak_* screen_x screen_y  pop && !empty
// config    cfg_valid cfg_ready cfg_index cfg_data    cfg_valid && cfg_ready
//
// One pixel per cycle while full is low; the search is a compare and counter update per pixel.
// A frame result passes the record queue and then the mapper's 4 stages before it shows.
// full rises when the record queue fills, and during a grid_step write and
// after it while the grid phase is recomputed bit by bit.
// Reset restores the register defaults and starts at column 0, row 0.
// ----------------------------------------------------------------------------
module grid_peak_pixel_locator #(
	parameter int COORD_BITS = 10,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [gppl_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [gppl_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                    push,
	output logic                                    full,
	input  logic [PIXEL_BITS-1:0]                   pixel,
	input  logic                                    frame_start,
	output logic                                    empty,
	input  logic                                    pop,
	output logic                                    found,
	output logic [COORD_BITS-1:0]                   peak_x,
	output logic [COORD_BITS-1:0]                   peak_y,
	output logic [PIXEL_BITS-1:0]                   peak_level,
	output logic signed [gppl_pkg::SCREEN_X_W-1:0]  screen_x,
	output logic signed [gppl_pkg::SCREEN_Y_W-1:0]  screen_y
);
	import gppl_pkg::*;

	localparam int REC_W = 2*COORD_BITS + PIXEL_BITS + 1;

	qstat_t           qstat;
	logic             enq, deq;
	logic [REC_W-1:0] enq_data, rec;

	gppl_front #(
		.COORD_BITS (COORD_BITS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.pixel       (pixel),
		.frame_start (frame_start),
		.qstat       (qstat),
		.enq         (enq),
		.enq_data    (enq_data)
	);

	gppl_queue #(
		.WIDTH (REC_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (enq),
		.wr_data (enq_data),
		.rd_en   (deq),
		.rd_data (rec),
		.qstat   (qstat)
	);

	gppl_back #(
		.COORD_BITS (COORD_BITS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.rec        (rec),
		.deq        (deq),
		.empty      (empty),
		.pop        (pop),
		.found      (found),
		.peak_x     (peak_x),
		.peak_y     (peak_y),
		.peak_level (peak_level),
		.screen_x   (screen_x),
		.screen_y   (screen_y)
	);

endmodule

// File: dv/tb_grid_peak_pixel_locator.sv
// ----------------------------------------------------------------------------
// tb_grid_peak_pixel_locator - frame peak locator regression
// Streams raster frames through the pixel queue under several register
// settings and checks each frame report against a cycle-free model of the
// grid sampling, peak tracking and screen mapping. Both sides idle at
// random, and the report side holds off once long enough to back up the
// pixel side.
// ----------------------------------------------------------------------------
module tb_grid_peak_pixel_locator;
	import gppl_pkg::*;

	localparam int COORD_LIMIT = (1 << DIM_W) - 1;
	localparam int X_ORIGIN = 147;
	localparam int SX_BIAS  = 1814528;
	localparam int SX_GAIN  = 12288;
	localparam int SX_DIV   = 443;
	localparam int Y_ORIGIN = 90;
	localparam int SY_BIAS  = 599040;
	localparam int SY_GAIN  = 6912;
	localparam int SY_DIV   = 260;

	typedef struct {
		logic [7:0] value;
		logic       first;
	} depth_px_t;

	typedef struct {
		logic                         found;
		logic [DIM_W-1:0]             px;
		logic [DIM_W-1:0]             py;
		logic [7:0]                   level;
		logic signed [SCREEN_X_W-1:0] sx;
		logic signed [SCREEN_Y_W-1:0] sy;
	} peak_report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic push;
	logic full;
	logic [7:0] pixel;
	logic frame_start;
	logic empty;
	logic pop;
	logic found;
	logic [DIM_W-1:0] peak_x;
	logic [DIM_W-1:0] peak_y;
	logic [7:0] peak_level;
	logic signed [SCREEN_X_W-1:0] screen_x;
	logic signed [SCREEN_Y_W-1:0] screen_y;

	grid_peak_pixel_locator uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// register mirror
	logic [DIM_W-1:0]    set_width;
	logic [DIM_W-1:0]    set_height;
	logic [MARGIN_W-1:0] set_margin;
	logic [THR_W-1:0]    set_threshold;
	logic [STEP_W-1:0]   set_step;

	// frame tracking mirror
	logic [DIM_W-1:0] col_cnt;
	logic [DIM_W-1:0] row_cnt;
	logic [7:0]       best_level;
	logic [DIM_W-1:0] best_col;
	logic [DIM_W-1:0] best_row;
	bit               have_peak;

	depth_px_t    pixel_feed[$];
	peak_report_t peak_reports[$];
	int           pixels_queued = 0;
	int           pixels_accepted = 0;
	int           fail_count = 0;

	bit         pixel_taken = 1'b0;
	bit         offering = 1'b0;
	int         pixel_gap = 0;
	bit         pixel_calm = 1'b0;
	depth_px_t  held_px;
	bit         report_taken = 1'b0;
	bit         popping = 1'b0;
	int         report_gap = 0;
	bit         result_calm = 1'b0;
	bit         result_hold = 1'b0;
	bit         hold_request = 1'b0;
	int         feed_pos = 0;
	logic [7:0] last_level = 8'd0;

	function automatic void restart_frame();
		col_cnt = '0;
		row_cnt = '0;
		best_level = '0;
		best_col = '0;
		best_row = '0;
		have_peak = 1'b0;
	endfunction

	function automatic int frame_pixels();
		return (set_width == 0 ? 1 : int'(set_width)) * (set_height == 0 ? 1 : int'(set_height));
	endfunction

	task automatic scan_pixel(input logic [7:0] pix, input logic fs);
		int w, h, stp, x, y, sx, sy;
		bit line_done, frame_done;
		peak_report_t rec;
		w = (set_width == 0) ? 1 : int'(set_width);
		h = (set_height == 0) ? 1 : int'(set_height);
		stp = (set_step == 0) ? 1 : int'(set_step);
		if (fs)
			restart_frame();
		x = int'(col_cnt);
		y = int'(row_cnt);
		if ((x % stp) == 0 && (y % stp) == 0 && x >= set_margin && y >= set_margin &&
				x + set_margin <= w && y + set_margin <= h && pix > set_threshold &&
				(!have_peak || pix > best_level)) begin
			best_level = pix;
			best_col = DIM_W'(x);
			best_row = DIM_W'(y);
			have_peak = 1'b1;
		end
		line_done = (x + 1 >= w) || (x >= COORD_LIMIT);
		frame_done = line_done && ((y + 1 >= h) || (y >= COORD_LIMIT));
		if (!frame_done) begin
			if (line_done) begin
				col_cnt = '0;
				row_cnt = DIM_W'(y + 1);
			end else begin
				col_cnt = DIM_W'(x + 1);
			end
			return;
		end
		rec = '{1'b0, '0, '0, '0, '0, '0};
		if (have_peak) begin
			sx = (SX_BIAS + (int'(best_col) - X_ORIGIN) * SX_GAIN) / SX_DIV;
			sy = -((SY_BIAS + (int'(best_row) - Y_ORIGIN) * SY_GAIN) / SY_DIV);
			if (sx > SX_MAX) sx = SX_MAX;
			if (sx < -SX_MAX - 1) sx = -SX_MAX - 1;
			if (sy > SY_MAX) sy = SY_MAX;
			if (sy < -SY_MIN_MAG) sy = -SY_MIN_MAG;
			rec.found = 1'b1;
			rec.px = best_col;
			rec.py = best_row;
			rec.level = best_level;
			rec.sx = sx[SCREEN_X_W-1:0];
			rec.sy = sy[SCREEN_Y_W-1:0];
		end
		peak_reports.push_back(rec);
		restart_frame();
	endtask

	function automatic int field_diff(string field_name, int want, int got);
		if (want == got)
			return 0;
		$display("%0t: %s expected %0d, got %0d", $time, field_name, want, got);
		return 1;
	endfunction

	function automatic int draw_gap(bit calm);
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic logic [7:0] draw_level();
		logic [7:0] v;
		case ($urandom_range(0, 3))
			0: v = 8'($urandom_range(0, 255));
			1: v = 8'(set_threshold + $urandom_range(0, 1));
			2: v = last_level;
			default: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		endcase
		return v;
	endfunction

	// pixel request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (pixel_taken) begin
				pixel_taken = 1'b0;
				offering = 1'b0;
				pixel_gap = draw_gap(pixel_calm);
			end
			if (!offering && pixel_feed.size() > 0) begin
				if (pixel_gap > 0) begin
					pixel_gap--;
				end else begin
					offering = 1'b1;
					held_px = pixel_feed.pop_front();
					pixel <= held_px.value;
					frame_start <= held_px.first;
				end
			end
			push <= offering;
		end
	end

	// report request receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (report_taken) begin
				report_taken = 1'b0;
				popping = 1'b0;
				report_gap = draw_gap(result_calm);
			end
			if (!popping) begin
				if (report_gap > 0)
					report_gap--;
				else
					popping = 1'b1;
			end
			pop <= popping && !result_hold;
		end
	end

	// monitor
	always @(posedge clk) begin
		peak_report_t want;
		if (arst_n) begin
			if (push && !full) begin
				scan_pixel(pixel, frame_start);
				pixels_accepted++;
				pixel_taken = 1'b1;
			end
			if (pop && !empty) begin
				report_taken = 1'b1;
				if (peak_reports.size() == 0) begin
					$display("%0t: frame report with none pending: found=%0b x=%0d y=%0d level=%0d",
						$time, found, peak_x, peak_y, peak_level);
					fail_count++;
				end else begin
					want = peak_reports.pop_front();
					fail_count += field_diff("found", int'(want.found), int'(found));
					fail_count += field_diff("peak_x", int'(want.px), int'(peak_x));
					fail_count += field_diff("peak_y", int'(want.py), int'(peak_y));
					fail_count += field_diff("peak_level", int'(want.level), int'(peak_level));
					fail_count += field_diff("screen_x", int'(want.sx), int'(screen_x));
					fail_count += field_diff("screen_y", int'(want.sy), int'(screen_y));
				end
			end
		end
	end

	// long report stall so the pixel side backs up
	initial begin
		wait (hold_request);
		@(posedge clk);
		result_hold = 1'b1;
		repeat (400) @(posedge clk);
		result_hold = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("grid_peak_pixel_locator regression: fail");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FRAME_WIDTH:     set_width = value;
			CFG_FRAME_HEIGHT:    set_height = value;
			CFG_EDGE_MARGIN:     set_margin = value[MARGIN_W-1:0];
			CFG_LEVEL_THRESHOLD: set_threshold = value[THR_W-1:0];
			CFG_GRID_STEP:       set_step = value[STEP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_setup(input int w, input int h, input int m, input int t, input int s);
		write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
		write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
		write_reg(CFG_EDGE_MARGIN, CFG_DATA_W'(m));
		write_reg(CFG_LEVEL_THRESHOLD, CFG_DATA_W'(t));
		write_reg(CFG_GRID_STEP, CFG_DATA_W'(s));
	endtask

	task automatic add_pixel(input logic [7:0] value, input logic fs);
		pixel_feed.push_back('{value, fs});
		pixels_queued++;
		last_level = value;
	endtask

	// whole frames with random content; broken adds rare mid-frame restarts
	task automatic add_frames(input int target, input bit broken);
		int added, fsize;
		logic fs;
		fsize = frame_pixels();
		added = 0;
		feed_pos = 0;
		while (added < target || feed_pos != 0) begin
			if (feed_pos == 0)
				fs = ($urandom_range(0, 7) != 0);
			else
				fs = broken && ($urandom_range(0, 3 * fsize - 1) == 0);
			if (fs)
				feed_pos = 0;
			add_pixel(draw_level(), fs);
			added++;
			feed_pos = (feed_pos + 1) % fsize;
		end
	endtask

	task automatic settle();
		while (pixels_accepted != pixels_queued || peak_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int w, h, m, t, s;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		pixel = '0;
		frame_start = 1'b0;
		pop = 1'b0;
		set_width = RST_FRAME_WIDTH;
		set_height = RST_FRAME_HEIGHT;
		set_margin = RST_EDGE_MARGIN;
		set_threshold = RST_THRESHOLD;
		set_step = RST_GRID_STEP;
		restart_frame();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// default width, threshold and step: one full-width line with no margin
		write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(1));
		write_reg(CFG_EDGE_MARGIN, CFG_DATA_W'(0));
		add_frames(1, 1'b0);
		settle();

		// ties, extremes, early and missing frame start, nothing found
		apply_setup(3, 2, 0, 0, 1);
		add_pixel(8'd7, 1'b1);
		add_pixel(8'd9, 1'b0);
		add_pixel(8'd9, 1'b0);
		add_pixel(8'd255, 1'b0);
		add_pixel(8'd255, 1'b0);
		add_pixel(8'd0, 1'b0);
		add_pixel(8'd40, 1'b1);
		add_pixel(8'd50, 1'b0);
		add_pixel(8'd60, 1'b0);
		for (int i = 0; i < 6; i++)
			add_pixel(8'd0, i == 0);
		for (int i = 0; i < 6; i++)
			add_pixel(i == 0 ? 8'd1 : (i == 5 ? 8'd2 : 8'd0), 1'b0);
		settle();

		// single tall column, zero grid step, a deep row saturates screen_y
		apply_setup(1, 630, 0, 0, 0);
		for (int y = 0; y < 630; y++)
			add_pixel(y == 625 ? 8'd200 : (y == 5 ? 8'd100 : 8'd0), y == 0);
		settle();

		apply_setup(0, 0, 0, 0, 1);
		add_frames(40, 1'b0);
		settle();

		// report side stalls while pixels keep coming
		apply_setup(2, 2, 0, 60, 1);
		pixel_calm = 1'b1;
		result_calm = 1'b0;
		hold_request = 1'b1;
		add_frames(120, 1'b0);
		settle();

		for (int i = 0; i < 11; i++) begin
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			h = $urandom_range(1, 8);
			m = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 2);
			t = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 30);
			s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
			if (i == 0)
				t = 255;
			if (i == 1)
				m = 511;
			if (i == 2)
				s = 63;
			apply_setup(w, h, m, t, s);
			pixel_calm = ($urandom_range(0, 3) == 0);
			result_calm = ($urandom_range(0, 3) == 0);
			add_frames(10, 1'b1);
			settle();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("grid_peak_pixel_locator regression: pass");
		else
			$display("grid_peak_pixel_locator regression: fail");
		$finish;
	end

endmodule
